// ===== src/pett_pkg.sv =====
// Package for the per-process event trace table: sizes, codes, types.
package pett_pkg;

    localparam int SLOTS = 64;
    localparam int RECS = 16;
    localparam int DEPTH = SLOTS * RECS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_X = (SLOT_W > 6) ? SLOT_W : 6;
    localparam int CNT_W = $clog2(RECS + 1);

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_COUNT  = 2'd1;
    localparam logic [1:0] REQ_SORT   = 2'd2;
    localparam logic [1:0] REQ_DUMP   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [5:0]  code;
        logic [37:0] stamp;
    } rec_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_SI_RD,
        S_SI_WT,
        S_SI_WB,
        S_FIN
    } state_t;

    typedef struct packed {
        logic             accept;
        logic             look;
        logic             app;
        logic             empty;
        logic             scan_issue;
        logic             rd_i;
        logic             ri_load;
        logic             wb;
        logic             fin;
        logic [CNT_W-1:0] idx;
        logic [CNT_W-1:0] i_idx;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       req;
        logic [CNT_W-1:0] fill;
    } sts_t;

endpackage

// ===== src/pett_ctrl.sv =====
// Controller state machine: sequences append, count, sort and dump requests.
module pett_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  pett_pkg::sts_t  sts,
    output pett_pkg::cmd_t  cmd,
    output logic            busy
);

    pett_pkg::state_t              state_reg, state_next;
    logic [pett_pkg::CNT_W-1:0]    idx_reg, idx_next;
    logic [pett_pkg::CNT_W-1:0]    i_reg, i_next;
    logic [pett_pkg::CNT_W-1:0]    i_inc;
    logic                          more;

    assign i_inc = i_reg + pett_pkg::CNT_W'(1);
    assign more  = idx_reg < sts.fill;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pett_pkg::S_IDLE;
            idx_reg   <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            i_reg     <= i_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        i_next     = i_reg;
        unique case (state_reg)
            pett_pkg::S_IDLE:
            begin
                if (start)
                    state_next = pett_pkg::S_LOOK;
            end
            pett_pkg::S_LOOK:
            begin
                idx_next = '0;
                i_next   = '0;
                unique case (sts.req)
                    pett_pkg::REQ_APPEND: state_next = pett_pkg::S_IDLE;
                    pett_pkg::REQ_COUNT:  state_next = pett_pkg::S_SCAN;
                    pett_pkg::REQ_SORT:
                        state_next = (sts.fill == '0) ? pett_pkg::S_FIN : pett_pkg::S_SI_RD;
                    default:
                        state_next = (sts.fill == '0) ? pett_pkg::S_IDLE : pett_pkg::S_SCAN;
                endcase
            end
            pett_pkg::S_SCAN:
            begin
                if (more)
                    idx_next = idx_reg + pett_pkg::CNT_W'(1);
                else
                begin
                    unique case (sts.req)
                        pett_pkg::REQ_SORT: state_next = pett_pkg::S_SI_WB;
                        pett_pkg::REQ_DUMP: state_next = pett_pkg::S_IDLE;
                        default:            state_next = pett_pkg::S_FIN;
                    endcase
                end
            end
            pett_pkg::S_SI_RD:
                state_next = pett_pkg::S_SI_WT;
            pett_pkg::S_SI_WT:
            begin
                idx_next   = '0;
                state_next = pett_pkg::S_SCAN;
            end
            pett_pkg::S_SI_WB:
            begin
                i_next     = i_inc;
                state_next = (i_inc < sts.fill) ? pett_pkg::S_SI_RD : pett_pkg::S_FIN;
            end
            pett_pkg::S_FIN:
                state_next = pett_pkg::S_IDLE;
            default:
                state_next = pett_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.idx        = idx_reg;
        cmd.i_idx      = i_reg;
        busy           = (state_reg != pett_pkg::S_IDLE);
        unique case (state_reg)
            pett_pkg::S_IDLE:  cmd.accept = start;
            pett_pkg::S_LOOK:
            begin
                cmd.look  = 1'b1;
                cmd.app   = (sts.req == pett_pkg::REQ_APPEND);
                cmd.empty = (sts.req == pett_pkg::REQ_DUMP) && (sts.fill == '0);
            end
            pett_pkg::S_SCAN:  cmd.scan_issue = more;
            pett_pkg::S_SI_RD: cmd.rd_i = 1'b1;
            pett_pkg::S_SI_WT: cmd.ri_load = 1'b1;
            pett_pkg::S_SI_WB: cmd.wb = 1'b1;
            pett_pkg::S_FIN:   cmd.fin = 1'b1;
            default:           cmd.fin = 1'b0;
        endcase
    end

endmodule

// ===== src/pett_dp.sv =====
// Datapath: request latch, fill-level and record memories, compare and result words.
module pett_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  pett_pkg::cmd_t  cmd,
    output pett_pkg::sts_t  sts,
    input  logic [1:0]      req_type,
    input  logic [5:0]      slot_id,
    input  logic [5:0]      event_code,
    input  logic [37:0]     stamp,
    output logic            strobe,
    output logic [1:0]      status,
    output logic [4:0]      match_count,
    output logic [5:0]      rec_code,
    output logic [37:0]     rec_stamp,
    output logic            last
);

    logic [1:0]                    req_reg;
    logic [5:0]                    slot_reg;
    logic [5:0]                    code_reg;
    logic [37:0]                   stamp_reg;

    logic [pett_pkg::CNT_W-1:0]    fill_mem [pett_pkg::SLOTS];
    logic [pett_pkg::SLOTS-1:0]    fill_vld_reg;
    logic [pett_pkg::CNT_W-1:0]    fill_q_reg;
    logic                          fill_v_reg;

    pett_pkg::rec_t                rec_mem [pett_pkg::DEPTH];
    pett_pkg::rec_t                rd_q_reg;
    pett_pkg::rec_t                ri_reg;
    logic                          p_reg;
    logic [pett_pkg::CNT_W-1:0]    pidx_reg;
    logic [pett_pkg::CNT_W-1:0]    cnt_reg;

    logic                          strobe_reg;
    logic [1:0]                    status_reg;
    logic [4:0]                    count_reg;
    pett_pkg::rec_t                rec_reg;
    logic                          last_reg;

    logic [pett_pkg::SLOT_X-1:0]   in_slot_x, slot_x;
    logic [pett_pkg::SLOT_W-1:0]   in_sidx, sidx;
    logic                          slot_ok;
    logic [pett_pkg::CNT_W-1:0]    fill_raw, fill_eff;
    logic                          full;
    logic [pett_pkg::ADDR_W-1:0]   base, rd_addr, wr_addr;
    logic                          rd_en, wr_en, swap, app_wr;
    pett_pkg::rec_t                wr_data;

    assign in_slot_x = pett_pkg::SLOT_X'(slot_id);
    assign in_sidx   = in_slot_x[pett_pkg::SLOT_W-1:0];
    assign slot_x    = pett_pkg::SLOT_X'(slot_reg);
    assign sidx      = slot_x[pett_pkg::SLOT_W-1:0];
    assign slot_ok   = (32'(slot_reg) < pett_pkg::SLOTS);
    assign fill_raw  = fill_v_reg ? fill_q_reg : '0;
    assign fill_eff  = !slot_ok ? '0
                     : ((32'(fill_raw) > pett_pkg::RECS) ? pett_pkg::CNT_W'(pett_pkg::RECS)
                                                         : fill_raw);
    assign full      = !slot_ok || (32'(fill_eff) >= pett_pkg::RECS);
    assign base      = pett_pkg::ADDR_W'(32'(slot_x) * pett_pkg::RECS);

    assign sts.req   = req_reg;
    assign sts.fill  = fill_eff;

    assign rd_en   = cmd.scan_issue || cmd.rd_i;
    assign rd_addr = base + pett_pkg::ADDR_W'(cmd.rd_i ? cmd.i_idx : cmd.idx);
    assign swap    = p_reg && (req_reg == pett_pkg::REQ_SORT) && (pidx_reg != cmd.i_idx)
                     && (rd_q_reg.code > ri_reg.code);
    assign app_wr  = cmd.app && !full;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = base;
        wr_data = ri_reg;
        priority if (app_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = base + pett_pkg::ADDR_W'(fill_eff);
            wr_data = '{code: code_reg, stamp: stamp_reg};
        end
        else if (swap)
        begin
            wr_en   = 1'b1;
            wr_addr = base + pett_pkg::ADDR_W'(pidx_reg);
        end
        else if (cmd.wb)
        begin
            wr_en   = 1'b1;
            wr_addr = base + pett_pkg::ADDR_W'(cmd.i_idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg    <= req_type;
            slot_reg   <= slot_id;
            code_reg   <= event_code;
            stamp_reg  <= stamp;
            fill_q_reg <= fill_mem[in_sidx];
            fill_v_reg <= fill_vld_reg[in_sidx];
        end
        if (app_wr)
            fill_mem[sidx] <= fill_eff + pett_pkg::CNT_W'(1);
        if (wr_en)
            rec_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_q_reg <= rec_mem[rd_addr];
        if (cmd.ri_load || swap)
            ri_reg <= rd_q_reg;
        pidx_reg <= cmd.idx;
        if (cmd.look)
            cnt_reg <= '0;
        else if (p_reg && (req_reg == pett_pkg::REQ_COUNT) && (rd_q_reg.code == code_reg))
            cnt_reg <= cnt_reg + pett_pkg::CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_vld_reg <= '0;
            p_reg        <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            if (app_wr)
                fill_vld_reg[sidx] <= 1'b1;
            p_reg      <= cmd.scan_issue;
            strobe_reg <= cmd.app || cmd.empty || cmd.fin
                          || (p_reg && (req_reg == pett_pkg::REQ_DUMP));
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= pett_pkg::ST_OK;
        count_reg  <= '0;
        rec_reg    <= '0;
        last_reg   <= 1'b1;
        if (cmd.app)
            status_reg <= full ? pett_pkg::ST_FULL : pett_pkg::ST_OK;
        else if (cmd.empty)
            status_reg <= pett_pkg::ST_EMPTY;
        else if (cmd.fin)
            count_reg <= (req_reg == pett_pkg::REQ_COUNT) ? 5'(cnt_reg) : '0;
        else if (p_reg && (req_reg == pett_pkg::REQ_DUMP))
        begin
            rec_reg  <= rd_q_reg;
            last_reg <= (pidx_reg == fill_eff - pett_pkg::CNT_W'(1));
        end
    end

    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign match_count = count_reg;
    assign rec_code    = rec_reg.code;
    assign rec_stamp   = rec_reg.stamp;
    assign last        = last_reg;

endmodule

// ===== src/per_process_event_trace_table_core.sv =====
// Top level of the per-process event trace table: controller plus datapath.
//
// A request word is taken when start is high and busy is low. Fields:
// req_type (append, count, sort, dump), slot_id, event_code and stamp.
// Every result word shows on the result ports for one cycle with strobe
// high; the receiver cannot stall and must take it then. last marks the
// final word of a request. Append, count and sort give one word; dump gives
// one word per stored record in position order, or one empty-status word.
// Dump words follow one per cycle. Within each scan pass the sort runs one
// record compare per cycle over the single record memory port pair; the
// fill level is read once per request, when the request is taken.
// busy falls at the edge that puts the final word on the ports, so the next
// request can be taken at the edge that takes that word.
// Reset clears the per-slot fill levels at once through valid bits; no
// clearing pass runs, and the first request can be taken right after reset.
module per_process_event_trace_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [5:0]  slot_id,
    input  logic [5:0]  event_code,
    input  logic [37:0] stamp,
    output logic        strobe,
    output logic [1:0]  status,
    output logic [4:0]  match_count,
    output logic [5:0]  rec_code,
    output logic [37:0] rec_stamp,
    output logic        last
);

    pett_pkg::cmd_t cmd;
    pett_pkg::sts_t sts;

    pett_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    pett_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .slot_id     (slot_id),
        .event_code  (event_code),
        .stamp       (stamp),
        .strobe      (strobe),
        .status      (status),
        .match_count (match_count),
        .rec_code    (rec_code),
        .rec_stamp   (rec_stamp),
        .last        (last)
    );

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result word without a request in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("word directly after final word");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status == pett_pkg::ST_EMPTY || status == pett_pkg::ST_FULL)) |-> last)
        else $error("error status on a non-final word");

endmodule

// ===== tb/per_process_event_trace_table_core_tb.sv =====
// Testbench for the per-process event trace table core: scoreboard class and stimulus.
module per_process_event_trace_table_core_tb;
    import pett_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  match_count;
        logic [5:0]  rec_code;
        logic [37:0] rec_stamp;
        logic        last;
    } word_t;

    class trace_scoreboard;
        logic [4:0]  fill [SLOTS];
        logic [5:0]  codes [SLOTS][RECS];
        logic [37:0] stamps [SLOTS][RECS];
        word_t       pending [$];
        int          errors;
        int          words_seen;

        function void clear();
            foreach (fill[s])
            begin
                fill[s] = '0;
            end
            pending.delete();
            errors = 0;
            words_seen = 0;
        endfunction

        function void push(logic [1:0] st, logic [4:0] cnt, logic [5:0] c,
                           logic [37:0] ts, logic lst);
            word_t w;
            w.status = st;
            w.match_count = cnt;
            w.rec_code = c;
            w.rec_stamp = ts;
            w.last = lst;
            pending.push_back(w);
        endfunction

        function void note_request(logic [1:0] req, logic [5:0] slot, logic [5:0] code,
                                   logic [37:0] ts);
            int n;
            int f;
            logic [5:0]  tc;
            logic [37:0] tst;
            f = fill[slot];
            n = 0;
            case (req)
                REQ_APPEND:
                begin
                    if (f >= RECS)
                        push(ST_FULL, '0, '0, '0, 1'b1);
                    else
                    begin
                        codes[slot][f] = code;
                        stamps[slot][f] = ts;
                        fill[slot] = 5'(f + 1);
                        push(ST_OK, '0, '0, '0, 1'b1);
                    end
                end
                REQ_COUNT:
                begin
                    for (int i = 0; i < f; i++)
                        if (codes[slot][i] == code)
                            n++;
                    push(ST_OK, n[4:0], '0, '0, 1'b1);
                end
                REQ_SORT:
                begin
                    for (int i = 0; i < f; i++)
                        for (int j = 0; j < f; j++)
                            if (codes[slot][j] > codes[slot][i])
                            begin
                                tc = codes[slot][i];
                                tst = stamps[slot][i];
                                codes[slot][i] = codes[slot][j];
                                stamps[slot][i] = stamps[slot][j];
                                codes[slot][j] = tc;
                                stamps[slot][j] = tst;
                            end
                    push(ST_OK, '0, '0, '0, 1'b1);
                end
                default:
                begin
                    if (f == 0)
                        push(ST_EMPTY, '0, '0, '0, 1'b1);
                    else
                        for (int i = 0; i < f; i++)
                            push(ST_OK, '0, codes[slot][i], stamps[slot][i], i == f - 1);
                end
            endcase
        endfunction

        function void check_word(word_t got);
            word_t exp;
            words_seen++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status)
            begin
                $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.match_count !== exp.match_count)
            begin
                $display("%0t: match_count exp %0d got %0d", $time, exp.match_count,
                         got.match_count);
                errors++;
            end
            if (got.rec_code !== exp.rec_code)
            begin
                $display("%0t: rec_code exp %0d got %0d", $time, exp.rec_code, got.rec_code);
                errors++;
            end
            if (got.rec_stamp !== exp.rec_stamp)
            begin
                $display("%0t: rec_stamp exp %h got %h", $time, exp.rec_stamp, got.rec_stamp);
                errors++;
            end
            if (got.last !== exp.last)
            begin
                $display("%0t: last exp %0d got %0d", $time, exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [5:0]  slot_id;
    logic [5:0]  event_code;
    logic [37:0] stamp;
    logic        strobe;
    logic [1:0]  status;
    logic [4:0]  match_count;
    logic [5:0]  rec_code;
    logic [37:0] rec_stamp;
    logic        last;

    trace_scoreboard sb;
    int idle_pct;
    int req_seen [4];

    per_process_event_trace_table_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .slot_id     (slot_id),
        .event_code  (event_code),
        .stamp       (stamp),
        .strobe      (strobe),
        .status      (status),
        .match_count (match_count),
        .rec_code    (rec_code),
        .rec_stamp   (rec_stamp),
        .last        (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_word({status, match_count, rec_code, rec_stamp, last});
    end

    task automatic send_request(logic [1:0] req, logic [5:0] slot, logic [5:0] code,
                                logic [37:0] ts);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req_type <= req;
        slot_id <= slot;
        event_code <= code;
        stamp <= ts;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        sb.note_request(req, slot, code, ts);
        req_seen[req]++;
        @(negedge clk);
    endtask

    function automatic logic [37:0] rand_stamp();
        return 38'({$urandom(), $urandom()});
    endfunction

    task automatic random_phase(int count);
        logic [5:0] slot;
        int r;
        for (int k = 0; k < count; k++)
        begin
            slot = 6'($urandom_range(7));
            if ($urandom_range(9) == 0)
                slot = 6'($urandom_range(63));
            r = $urandom_range(99);
            if (r < 50)
                send_request(REQ_APPEND, slot, 6'($urandom_range(7)), rand_stamp());
            else if (r < 65)
                send_request(REQ_COUNT, slot, 6'($urandom_range(7)), rand_stamp());
            else if (r < 80)
                send_request(REQ_SORT, slot, 6'($urandom()), rand_stamp());
            else
                send_request(REQ_DUMP, slot, 6'($urandom()), rand_stamp());
        end
    endtask

    initial
    begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int guard;
        sb = new();
        sb.clear();
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_APPEND;
        slot_id = '0;
        event_code = '0;
        stamp = '0;
        idle_pct = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty dump, fill slot 63 past full, extremes, count, sort, dump
        send_request(REQ_DUMP, 6'd63, 6'd0, '0);
        send_request(REQ_COUNT, 6'd0, 6'd63, '0);
        send_request(REQ_SORT, 6'd0, 6'd0, '0);
        for (int k = 0; k < 17; k++)
            send_request(REQ_APPEND, 6'd63, (k % 3 == 0) ? 6'd63 : 6'(k % 4),
                         (k == 0) ? '1 : (k == 1) ? '0 : rand_stamp());
        send_request(REQ_COUNT, 6'd63, 6'd63, '1);
        send_request(REQ_SORT, 6'd63, 6'd0, '0);
        send_request(REQ_DUMP, 6'd63, 6'd63, '1);

        idle_pct = 23;
        random_phase(110);
        idle_pct = 55;
        random_phase(100);
        idle_pct = 0;
        random_phase(90);
        for (int s = 0; s < 8; s++)
            send_request(REQ_DUMP, s[5:0], '0, '0);
        start <= 1'b0;

        guard = 0;
        while (sb.pending.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (400) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $display("%0t: %0d words never arrived", $time, sb.pending.size());
            sb.errors++;
        end
        $display("Covered %0d appends, %0d counts, %0d sorts, %0d dumps; %0d words checked",
                 req_seen[0], req_seen[1], req_seen[2], req_seen[3], sb.words_seen);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/pett_pkg.sv
src/pett_ctrl.sv
src/pett_dp.sv
src/per_process_event_trace_table_core.sv
tb/per_process_event_trace_table_core_tb.sv
